[src/mme_pkg.sv]
// matrix multiply engine package: payload structs, request and register codes
// and default sizes; no dependencies, compiled first
package mme_pkg;

  // fixed field widths of the ports
  localparam int ROW_W      = 6;
  localparam int ELEM_IN_W  = 16;
  localparam int PROD_W     = 40;
  localparam int CFG_W      = 7;
  localparam int CFG_IDX_W  = 2;
  // width for effective sizes, covers a dimension of up to 256
  localparam int SZ_W       = 9;

  // defaults for the top level parameters
  localparam int MAX_DIM_DEF   = 64;
  localparam int ELEM_BITS_DEF = 16;

  // request codes, code 3 is unused and ignored
  typedef enum logic [1:0] {
    REQ_LOAD_LEFT  = 2'd0,
    REQ_LOAD_RIGHT = 2'd1,
    REQ_COMPUTE    = 2'd2
  } req_type_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_LEN = 2'd2;

  typedef struct packed {
    req_type_t                     req_type;
    logic [ROW_W-1:0]              row_index;
    logic [ROW_W-1:0]              col_index;
    logic signed [ELEM_IN_W-1:0]   elem_value;
  } in_item_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] product_value;
    logic                     index_error;
  } out_item_t;

endpackage

[src/mme_ram.sv]
// generic simple dual port ram: one write port, one registered read port
// no dependencies
module mme_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/matrix_multiply_engine.sv]
// matrix multiply engine top level: two element stores, read pipeline and
// multiply-accumulate; depends on mme_pkg and mme_ram
//
//   channel   ports                               handshake
//   input     start, busy, in_data                start high while busy low
//   result    out_valid, out_data                 one-cycle strobe, no stall
//   config    cfg_we, cfg_index, cfg_wdata        write on cfg_we, no wait
//
// a load transaction leaves busy low
// a compute transaction holds busy while it issues one store read per cycle for
// min(inner_len, MAX_DIM) elements, then while the registered ram read and the
// multiplier register drain; the result strobe comes in the cycle busy drops
// an index error or an empty inner length gives the result in the next cycle
// reset is synchronous, clears control and sets the size registers to 1; store content is undefined
// until loaded; results cannot be held off by the receiver
module matrix_multiply_engine #(
  parameter int MAX_DIM   = mme_pkg::MAX_DIM_DEF,
  parameter int ELEM_BITS = mme_pkg::ELEM_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  mme_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  output mme_pkg::out_item_t                out_data,
  input  logic                              cfg_we,
  input  logic [mme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mme_pkg::CFG_W-1:0]         cfg_wdata
);

  import mme_pkg::*;

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(MAX_DIM + 1);
  localparam int MUL_W  = 2 * ELEM_BITS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CFG_W-1:0]         rows_r, cols_r, inner_r;
  logic [CNT_W-1:0]         remain_r, remain_nxt;
  logic [ADDR_W-1:0]        laddr_r, laddr_nxt;
  logic [ADDR_W-1:0]        raddr_r, raddr_nxt;
  logic                     rd_vld_r, mul_vld_r;
  logic signed [MUL_W-1:0]  mul_r;
  logic [PROD_W-1:0]        acc_r, acc_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_item_t                out_data_r, out_data_nxt;

  logic [SZ_W-1:0]          m_eff, n_eff, k_eff;
  logic [SZ_W-1:0]          row_ext, col_ext;
  logic                     accept, issue;
  logic                     we_left, we_right;
  logic                     bad_index;
  logic [ADDR_W-1:0]        waddr;
  logic signed [31:0]       elem_ext;
  logic [ELEM_BITS-1:0]     elem_st;
  logic [ELEM_BITS-1:0]     left_q, right_q;
  logic signed [63:0]       mul_ext;

  // effective sizes, clamped to the store dimension
  function automatic logic [SZ_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    logic [SZ_W-1:0] w;
    w = SZ_W'(v);
    return (w > SZ_W'(MAX_DIM)) ? SZ_W'(MAX_DIM) : w;
  endfunction

  assign m_eff   = clamp_size(rows_r);
  assign n_eff   = clamp_size(cols_r);
  assign k_eff   = clamp_size(inner_r);
  assign row_ext = SZ_W'(in_data.row_index);
  assign col_ext = SZ_W'(in_data.col_index);

  assign busy   = (state_r == ST_RUN);
  assign accept = start && !busy;

  // load decode and element formatting
  assign elem_ext = 32'(in_data.elem_value);
  assign elem_st  = elem_ext[ELEM_BITS-1:0];
  assign waddr    = ADDR_W'(32'(in_data.row_index) * MAX_DIM + 32'(in_data.col_index));
  assign we_left  = accept && (in_data.req_type == REQ_LOAD_LEFT)
                    && (row_ext < m_eff) && (col_ext < k_eff);
  assign we_right = accept && (in_data.req_type == REQ_LOAD_RIGHT)
                    && (row_ext < k_eff) && (col_ext < n_eff);
  assign bad_index = (row_ext >= m_eff) || (col_ext >= n_eff);

  assign issue = (state_r == ST_RUN) && (remain_r != '0);

  // element stores
  mme_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_left_ram (
    .clk   (clk),
    .we    (we_left),
    .waddr (waddr),
    .wdata (elem_st),
    .re    (issue),
    .raddr (laddr_r),
    .rdata (left_q)
  );

  mme_ram #(
    .WIDTH (ELEM_BITS),
    .DEPTH (DEPTH)
  ) u_right_ram (
    .clk   (clk),
    .we    (we_right),
    .waddr (waddr),
    .wdata (elem_st),
    .re    (issue),
    .raddr (raddr_r),
    .rdata (right_q)
  );

  // product extended or wrapped to the accumulator width
  assign mul_ext = 64'(mul_r);

  // sequencer and accumulator next state
  always_comb begin
    state_nxt     = state_r;
    remain_nxt    = remain_r;
    laddr_nxt     = laddr_r;
    raddr_nxt     = raddr_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    if (mul_vld_r) begin
      acc_nxt = acc_r + mul_ext[PROD_W-1:0];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.req_type == REQ_COMPUTE)) begin
          if (bad_index) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.product_value = '0;
            out_data_nxt.index_error   = 1'b1;
          end else if (k_eff == '0) begin
            out_valid_nxt              = 1'b1;
            out_data_nxt.product_value = '0;
            out_data_nxt.index_error   = 1'b0;
          end else begin
            state_nxt  = ST_RUN;
            remain_nxt = CNT_W'(k_eff);
            laddr_nxt  = ADDR_W'(32'(in_data.row_index) * MAX_DIM);
            raddr_nxt  = ADDR_W'(in_data.col_index);
            acc_nxt    = '0;
          end
        end
      end
      ST_RUN: begin
        if (issue) begin
          remain_nxt = remain_r - 1'b1;
          laddr_nxt  = laddr_r + 1'b1;
          raddr_nxt  = raddr_r + ADDR_W'(MAX_DIM);
        end else if (!rd_vld_r && !mul_vld_r) begin
          state_nxt                  = ST_IDLE;
          out_valid_nxt              = 1'b1;
          out_data_nxt.product_value = acc_r;
          out_data_nxt.index_error   = 1'b0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      remain_r    <= '0;
      rd_vld_r    <= 1'b0;
      mul_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rows_r      <= CFG_W'(1);
      cols_r      <= CFG_W'(1);
      inner_r     <= CFG_W'(1);
    end else begin
      state_r     <= state_nxt;
      remain_r    <= remain_nxt;
      rd_vld_r    <= issue;
      mul_vld_r   <= rd_vld_r;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_ROWS:  rows_r  <= cfg_wdata;
          CFG_NUM_COLS:  cols_r  <= cfg_wdata;
          CFG_INNER_LEN: inner_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    laddr_r    <= laddr_nxt;
    raddr_r    <= raddr_nxt;
    mul_r      <= $signed(left_q) * $signed(right_q);
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an error result always carries a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.index_error |-> out_data.product_value == '0)
    else $error("error result with nonzero sum");

  // a load transaction never raises busy
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_data.req_type != REQ_COMPUTE) |=> !busy)
    else $error("load raised busy");

  // read and multiply pipeline runs only inside a compute transaction
  a_pipe_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r || mul_vld_r || (remain_r != '0) |-> state_r == ST_RUN)
    else $error("pipeline active outside compute");

  // a compute run ends with a result strobe that carries no error
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid && !out_data.index_error)
    else $error("compute ended without result");

endmodule
